@@ design/assert_macros.svh @@
// Assertion macros used by the decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ design/rbgd_pkg.sv @@
// Types, codes and helper functions of the remote button gesture decoder.
package rbgd_pkg;

    typedef enum logic [2:0] {
        OP_PRESS   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_HOLD    = 3'd2,
        OP_PING    = 3'd3,
        OP_SLEEP   = 3'd4,
        OP_POLL    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        KIND_COMMAND = 3'd0,
        KIND_PRESS   = 3'd1,
        KIND_RELEASE = 3'd2,
        KIND_PING    = 3'd3,
        KIND_SLEEP   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        GEST_NONE     = 3'd0,
        GEST_CLICKED  = 3'd1,
        GEST_DOUBLE   = 3'd2,
        GEST_MULTIPLE = 3'd3,
        GEST_LONG     = 3'd4
    } gesture_t;

    localparam logic [2:0] CFG_CLICK_TIME        = 3'd0;
    localparam logic [2:0] CFG_WAIT_TIME         = 3'd1;
    localparam logic [2:0] CFG_FIRST_REPEAT_TIME = 3'd2;
    localparam logic [2:0] CFG_LATER_REPEAT_TIME = 3'd3;
    localparam logic [2:0] CFG_SLEEP_TIME        = 3'd4;
    localparam logic [2:0] CFG_CHATTER_GAP       = 3'd5;

    localparam logic [1:0] TYPE_SINGLE    = 2'd0;
    localparam logic [1:0] TYPE_REPEATING = 2'd1;
    localparam logic [1:0] TYPE_GESTURE   = 2'd2;

    localparam logic [31:0] BOUNCE_MS = 32'd30;
    localparam logic [31:0] REL_MASK  = 32'h0000_00FF;

    localparam int MAX_RES = 3;

    typedef struct packed {
        kind_t       kind;
        gesture_t    gesture;
        logic [31:0] code;
        logic        known;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        active;
        logic        release_pending;
        logic        release_sent;
        logic        hold_seen;
        logic        long_sent;
        logic        initial_sent;
        logic        hold_valid;
        logic [1:0]  repeat_phase;
        logic [1:0]  clicks;
        logic [31:0] press_start;
        logic [31:0] last_press;
        logic [31:0] last_release;
        logic [31:0] last_hold;
        logic [31:0] last_related;
        logic [31:0] next_repeat;
        logic [31:0] cur_code;
        logic [1:0]  cur_type;
        logic        cur_known;
    } seq_t;

    localparam seq_t SEQ_CLEAR = '0;

    function automatic seq_t seq_begin(logic [31:0] code, logic [1:0] ctype,
                                       logic known, logic [31:0] now);
        seq_t s;
        s              = SEQ_CLEAR;
        s.active       = 1'b1;
        s.clicks       = 2'd1;
        s.press_start  = now;
        s.last_press   = now;
        s.last_related = now;
        s.cur_code     = code;
        s.cur_type     = ctype;
        s.cur_known    = known;
        return s;
    endfunction

    function automatic res_t mk_res(kind_t kind, gesture_t gest, logic [31:0] code,
                                    logic known);
        res_t r;
        r.kind    = kind;
        r.gesture = gest;
        r.code    = code;
        r.known   = known;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic gesture_t click_gesture(logic [1:0] clicks);
        gesture_t g;
        unique case (clicks)
            2'd1:    g = GEST_CLICKED;
            2'd2:    g = GEST_DOUBLE;
            default: g = GEST_MULTIPLE;
        endcase
        return g;
    endfunction

endpackage

@@ design/remote_button_gesture_decoder_core.sv @@
// Remote button gesture decoder: press sequence tracking and event generation.
// Latency: the first result of an accepted item is valid in the cycle after its transfer.
// An item causing k results (0..3) holds the result buffer until its results have transferred;
// the next item is taken when the buffer is empty or its last result transfers.
// State and result buffer are updated in the accept cycle by one pass of logic.
// Reset: asynchronous, clears all sequence state and loads the register defaults.
`include "assert_macros.svh"

module remote_button_gesture_decoder_core
    import rbgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // command_code[31:0], command_type[33:32],
                                       // command_known[34], time_ms[66:35], zero pad
    input  logic [2:0]  s_axis_tuser,  // op[2:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // gesture[2:0], event_code[34:3],
                                       // event_known[35], zero pad
    output logic [2:0]  m_axis_tuser,  // event_kind[2:0]
    output logic        m_axis_tlast,  // last_event
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    logic [15:0] click_time_reg, wait_time_reg, first_repeat_reg, later_repeat_reg;
    logic [15:0] chatter_gap_reg;
    logic [23:0] sleep_time_reg;

    seq_t        seq_reg, seq_next;
    logic        awake_reg, awake_next;
    logic        ping_seen_reg, ping_seen_next;
    logic [31:0] last_activity_reg, last_activity_next;

    res_t        res_buf_reg [MAX_RES];
    res_t        res_next [MAX_RES];
    logic [1:0]  n_next;
    logic [1:0]  count_reg;
    logic [1:0]  rd_ptr_reg;

    logic        in_fire, out_fire;
    op_t         op;
    logic [31:0] code_in, now;
    logic [1:0]  type_in;
    logic        known_in;

    logic [31:0] wait32, click32, gap32;
    logic [31:0] d_rel, d_hold, d_start, d_press, d_related, d_repeat, d_act;
    logic        hold_cont, press_act;
    res_t        res_cur;

    assign cfg_ready = 1'b1;

    assign op       = op_t'(s_axis_tuser);
    assign code_in  = s_axis_tdata[31:0];
    assign type_in  = s_axis_tdata[33:32];
    assign known_in = s_axis_tdata[34];
    assign now      = s_axis_tdata[66:35];

    assign s_axis_tready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_axis_tready);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    assign wait32  = {16'd0, wait_time_reg};
    assign click32 = {16'd0, click_time_reg};
    assign gap32   = {16'd0, chatter_gap_reg};

    assign d_rel     = now - seq_reg.last_release;
    assign d_hold    = now - seq_reg.last_hold;
    assign d_start   = now - seq_reg.press_start;
    assign d_press   = now - seq_reg.last_press;
    assign d_related = now - seq_reg.last_related;
    assign d_repeat  = now - seq_reg.next_repeat;
    assign d_act     = now - last_activity_reg;

    assign hold_cont = seq_reg.active && seq_reg.release_pending && (d_rel <= gap32) &&
                       (seq_reg.hold_seen ||
                        (seq_reg.hold_valid && d_hold <= wait32) ||
                        (seq_reg.cur_type == TYPE_GESTURE && d_start >= click32));

    assign press_act = seq_reg.active && !seq_reg.release_pending && (d_related <= wait32);

    always_comb
    begin
        seq_next           = seq_reg;
        awake_next         = awake_reg;
        ping_seen_next     = ping_seen_reg;
        last_activity_next = last_activity_reg;
        n_next             = 2'd0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_next[i] = mk_res(KIND_COMMAND, GEST_NONE, 32'd0, 1'b0);
        end

        unique case (op)
            OP_PRESS:
            begin
                awake_next         = 1'b1;
                last_activity_next = now;
                if (!seq_reg.active || code_in != seq_reg.cur_code)
                begin
                    if (seq_reg.active && seq_reg.release_pending &&
                        seq_reg.cur_type == TYPE_GESTURE && !seq_reg.long_sent &&
                        seq_reg.clicks != 2'd0)
                    begin
                        res_next[n_next] = mk_res(KIND_COMMAND,
                                                  click_gesture(seq_reg.clicks),
                                                  seq_reg.cur_code, seq_reg.cur_known);
                        n_next = n_next + 2'd1;
                    end
                    seq_next = seq_begin(code_in, type_in, known_in, now);
                    if (n_next != 2'd3)
                    begin
                        res_next[n_next] = mk_res(KIND_PRESS, GEST_NONE, code_in, known_in);
                        n_next = n_next + 2'd1;
                    end
                end
                else if (seq_reg.release_pending)
                begin
                    seq_next.release_pending = 1'b0;
                    seq_next.last_press      = now;
                    seq_next.last_related    = now;
                    if (!hold_cont)
                    begin
                        seq_next.release_sent = 1'b0;
                        seq_next.hold_seen    = 1'b0;
                        seq_next.press_start  = now;
                        if (seq_reg.clicks != 2'd3)
                        begin
                            seq_next.clicks = seq_reg.clicks + 2'd1;
                        end
                        seq_next.initial_sent = 1'b0;
                        seq_next.repeat_phase = 2'd0;
                        seq_next.next_repeat  = 32'd0;
                        res_next[n_next] = mk_res(KIND_PRESS, GEST_NONE, code_in, known_in);
                        n_next = n_next + 2'd1;
                    end
                end
                else if (d_press > BOUNCE_MS)
                begin
                    seq_next.last_press   = now;
                    seq_next.last_related = now;
                end
            end
            OP_RELEASE:
            begin
                awake_next         = 1'b1;
                last_activity_next = now;
                if (seq_reg.active && code_in == (seq_reg.cur_code & REL_MASK))
                begin
                    seq_next.release_pending = 1'b1;
                    seq_next.release_sent    = 1'b0;
                    seq_next.last_release    = now;
                    seq_next.last_related    = now;
                end
            end
            OP_HOLD:
            begin
                awake_next         = 1'b1;
                last_activity_next = now;
                if (seq_reg.active)
                begin
                    seq_next.release_pending = 1'b0;
                    seq_next.hold_seen       = 1'b1;
                    seq_next.last_hold       = now;
                    seq_next.hold_valid      = 1'b1;
                    seq_next.last_related    = now;
                end
            end
            OP_PING:
            begin
                awake_next         = 1'b1;
                ping_seen_next     = 1'b1;
                last_activity_next = now;
                res_next[n_next] = mk_res(KIND_PING, GEST_NONE, 32'd0, 1'b1);
                n_next = n_next + 2'd1;
            end
            OP_SLEEP:
            begin
                last_activity_next = now;
                ping_seen_next     = 1'b0;
                awake_next         = 1'b0;
                seq_next           = SEQ_CLEAR;
                res_next[n_next] = mk_res(KIND_SLEEP, GEST_NONE, 32'd0, 1'b1);
                n_next = n_next + 2'd1;
            end
            OP_POLL:
            begin
                if (seq_reg.active)
                begin
                    if (seq_reg.release_pending && !seq_reg.release_sent && d_rel > gap32)
                    begin
                        res_next[n_next] = mk_res(KIND_RELEASE, GEST_NONE,
                                                  seq_reg.cur_code, seq_reg.cur_known);
                        n_next = n_next + 2'd1;
                        seq_next.release_sent = 1'b1;
                    end
                    if (seq_reg.cur_type <= TYPE_REPEATING)
                    begin
                        if (!seq_reg.initial_sent)
                        begin
                            res_next[n_next] = mk_res(KIND_COMMAND, GEST_NONE,
                                                      seq_reg.cur_code, seq_reg.cur_known);
                            n_next = n_next + 2'd1;
                            seq_next.initial_sent = 1'b1;
                            if (seq_reg.cur_type == TYPE_REPEATING)
                            begin
                                seq_next.repeat_phase = 2'd1;
                                seq_next.next_repeat  = now + {16'd0, first_repeat_reg};
                            end
                        end
                        else if (seq_reg.cur_type == TYPE_REPEATING && press_act &&
                                 seq_reg.hold_seen && !d_repeat[31])
                        begin
                            res_next[n_next] = mk_res(KIND_COMMAND, GEST_NONE,
                                                      seq_reg.cur_code, seq_reg.cur_known);
                            n_next = n_next + 2'd1;
                            seq_next.repeat_phase = 2'd2;
                            seq_next.next_repeat  = now + {16'd0, later_repeat_reg};
                        end
                        if (d_related > wait32)
                        begin
                            seq_next = SEQ_CLEAR;
                        end
                    end
                    else
                    begin
                        if (!seq_reg.long_sent && press_act && d_start >= click32)
                        begin
                            res_next[n_next] = mk_res(KIND_COMMAND, GEST_LONG,
                                                      seq_reg.cur_code, seq_reg.cur_known);
                            n_next = n_next + 2'd1;
                            seq_next.long_sent = 1'b1;
                        end
                        if (!seq_next.long_sent && seq_reg.release_pending &&
                            d_rel > wait32)
                        begin
                            if (seq_reg.cur_type == TYPE_GESTURE && seq_reg.clicks != 2'd0)
                            begin
                                res_next[n_next] = mk_res(KIND_COMMAND,
                                                          click_gesture(seq_reg.clicks),
                                                          seq_reg.cur_code,
                                                          seq_reg.cur_known);
                                n_next = n_next + 2'd1;
                            end
                            seq_next = SEQ_CLEAR;
                        end
                        else if (seq_next.long_sent && d_related > wait32)
                        begin
                            seq_next = SEQ_CLEAR;
                        end
                    end
                end
                if (awake_reg && ping_seen_reg && d_act > {8'd0, sleep_time_reg})
                begin
                    awake_next     = 1'b0;
                    ping_seen_next = 1'b0;
                    if (n_next != 2'd3)
                    begin
                        res_next[n_next] = mk_res(KIND_SLEEP, GEST_NONE, 32'd0, 1'b1);
                        n_next = n_next + 2'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (n_next != 2'd0)
        begin
            res_next[n_next - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_time_reg    <= 16'd500;
            wait_time_reg     <= 16'd300;
            first_repeat_reg  <= 16'd400;
            later_repeat_reg  <= 16'd100;
            sleep_time_reg    <= 24'd60000;
            chatter_gap_reg   <= 16'd50;
        end
        else if (cfg_valid && cfg_ready)
        begin
            priority case (cfg_index)
                CFG_CLICK_TIME:        click_time_reg   <= cfg_data[15:0];
                CFG_WAIT_TIME:         wait_time_reg    <= cfg_data[15:0];
                CFG_FIRST_REPEAT_TIME: first_repeat_reg <= cfg_data[15:0];
                CFG_LATER_REPEAT_TIME: later_repeat_reg <= cfg_data[15:0];
                CFG_SLEEP_TIME:        sleep_time_reg   <= cfg_data;
                CFG_CHATTER_GAP:       chatter_gap_reg  <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg           <= SEQ_CLEAR;
            awake_reg         <= 1'b0;
            ping_seen_reg     <= 1'b0;
            last_activity_reg <= 32'd0;
            count_reg         <= 2'd0;
            rd_ptr_reg        <= 2'd0;
        end
        else if (in_fire)
        begin
            seq_reg           <= seq_next;
            awake_reg         <= awake_next;
            ping_seen_reg     <= ping_seen_next;
            last_activity_reg <= last_activity_next;
            count_reg         <= n_next;
            rd_ptr_reg        <= 2'd0;
        end
        else if (out_fire)
        begin
            count_reg  <= count_reg - 2'd1;
            rd_ptr_reg <= rd_ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                res_buf_reg[i] <= res_next[i];
            end
        end
    end

    assign res_cur       = res_buf_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = {4'd0, res_cur.known, res_cur.code, res_cur.gesture};
    assign m_axis_tuser  = res_cur.kind;
    assign m_axis_tlast  = res_cur.last;

    `ASSERT_IMPLIES(a_last_drains_buffer, clk, rst_n, out_fire && m_axis_tlast, count_reg == 2'd1)
    `ASSERT_NEXT(a_ping_gives_result, clk, rst_n, in_fire && op == OP_PING, m_axis_tvalid)
    `ASSERT_IMPLIES(a_idle_seq_cleared, clk, rst_n, !seq_reg.active, seq_reg.clicks == 2'd0 && !seq_reg.release_pending)
    `ASSERT_IMPLIES(a_active_has_click, clk, rst_n, seq_reg.active, seq_reg.clicks != 2'd0)

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the gesture decoder: directed table, random press sequences, scoreboard.
module tb_top;
    import rbgd_pkg::*;

    localparam int LIMIT = 2000;
    localparam int SETTLE = 8;
    localparam int PREDICTED = -1;
    localparam int PHASE_ITEMS = 75;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam logic [2:0] CFG_SPARE6 = 3'd6;
    localparam logic [2:0] CFG_SPARE7 = 3'd7;
    localparam logic [1:0] TYPE_THREE = 2'd3;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] code;
        logic [1:0]  ctype;
        logic        known;
        logic [31:0] stamp;
        int          n_typed;
        kind_t       ekind;
        logic [31:0] ecode;
        logic        eknown;
    } row_t;

    typedef struct packed {
        kind_t       kind;
        gesture_t    gest;
        logic [31:0] code;
        logic        known;
        logic        last;
    } evt_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    remote_button_gesture_decoder_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // decoder state as predicted
    logic [31:0] click_ms, wait_ms, first_rep_ms, later_rep_ms, sleep_ms, chatter_ms;
    logic        in_seq, rel_wait, rel_told, held, long_told, first_told, hold_ok;
    logic        known_now, is_awake, pinged;
    logic [1:0]  taps, type_now;
    logic [31:0] t_start, t_press, t_release, t_hold, t_touch, t_next_rep, code_now, t_active;

    evt_t        fresh[$];
    evt_t        awaited[$];
    row_t        plan[$];
    logic [31:0] now_ms;
    bit          calm;
    int          fails = 0;
    int          quiet = 0;

    function automatic void emit_evt(kind_t k, gesture_t g, logic [31:0] c, logic kn);
        evt_t e;
        if (fresh.size() >= MAX_RES)
            return;
        e.kind  = k;
        e.gest  = g;
        e.code  = c;
        e.known = kn;
        e.last  = 1'b0;
        fresh.push_back(e);
    endfunction

    function automatic void drop_seq();
        in_seq     = 1'b0;
        rel_wait   = 1'b0;
        rel_told   = 1'b0;
        held       = 1'b0;
        long_told  = 1'b0;
        first_told = 1'b0;
        hold_ok    = 1'b0;
        taps       = '0;
        t_start    = '0;
        t_press    = '0;
        t_release  = '0;
        t_hold     = '0;
        t_touch    = '0;
        t_next_rep = '0;
        code_now   = '0;
        type_now   = '0;
        known_now  = 1'b0;
    endfunction

    function automatic void open_seq(logic [31:0] code, logic [1:0] ctype, logic kn,
                                     logic [31:0] now);
        drop_seq();
        in_seq    = 1'b1;
        taps      = 2'd1;
        t_start   = now;
        t_press   = now;
        t_touch   = now;
        code_now  = code;
        type_now  = ctype;
        known_now = kn;
    endfunction

    function automatic void close_clicks();
        gesture_t g;
        if (in_seq && type_now == TYPE_GESTURE && !long_told && taps != 2'd0)
        begin
            g = (taps == 2'd1) ? GEST_CLICKED : (taps == 2'd2) ? GEST_DOUBLE : GEST_MULTIPLE;
            emit_evt(KIND_COMMAND, g, code_now, known_now);
        end
        drop_seq();
    endfunction

    function automatic logic still_held(logic [31:0] now);
        if (!in_seq || !rel_wait)
            return 1'b0;
        if (now - t_release > chatter_ms)
            return 1'b0;
        if (held)
            return 1'b1;
        if (hold_ok && now - t_hold <= wait_ms)
            return 1'b1;
        if (type_now != TYPE_GESTURE)
            return 1'b0;
        return now - t_start >= click_ms;
    endfunction

    function automatic logic pressing(logic [31:0] now);
        return in_seq && !rel_wait && (now - t_touch) <= wait_ms;
    endfunction

    function automatic void take_press(logic [31:0] code, logic [1:0] ctype, logic kn,
                                       logic [31:0] now);
        is_awake = 1'b1;
        t_active = now;
        if (!in_seq)
        begin
            open_seq(code, ctype, kn, now);
            emit_evt(KIND_PRESS, GEST_NONE, code, kn);
            return;
        end
        if (code != code_now)
        begin
            if (rel_wait)
                close_clicks();
            open_seq(code, ctype, kn, now);
            emit_evt(KIND_PRESS, GEST_NONE, code, kn);
            return;
        end
        if (rel_wait)
        begin
            if (still_held(now))
            begin
                rel_wait = 1'b0;
                t_press  = now;
                t_touch  = now;
                return;
            end
            rel_wait   = 1'b0;
            rel_told   = 1'b0;
            held       = 1'b0;
            t_press    = now;
            t_touch    = now;
            t_start    = now;
            if (taps < 2'd3)
                taps = taps + 2'd1;
            first_told = 1'b0;
            t_next_rep = '0;
            emit_evt(KIND_PRESS, GEST_NONE, code, kn);
            return;
        end
        if (now - t_press <= BOUNCE_MS)
            return;
        t_press = now;
        t_touch = now;
    endfunction

    function automatic void take_poll(logic [31:0] now);
        logic [31:0] lag;
        if (in_seq)
        begin
            if (rel_wait && !rel_told && now - t_release > chatter_ms)
            begin
                emit_evt(KIND_RELEASE, GEST_NONE, code_now, known_now);
                rel_told = 1'b1;
            end
            if (type_now <= TYPE_REPEATING)
            begin
                lag = now - t_next_rep;
                if (!first_told)
                begin
                    emit_evt(KIND_COMMAND, GEST_NONE, code_now, known_now);
                    first_told = 1'b1;
                    if (type_now == TYPE_REPEATING)
                        t_next_rep = now + first_rep_ms;
                end
                else if (type_now == TYPE_REPEATING && pressing(now) && held && !lag[31])
                begin
                    emit_evt(KIND_COMMAND, GEST_NONE, code_now, known_now);
                    t_next_rep = now + later_rep_ms;
                end
                if (now - t_touch > wait_ms)
                    drop_seq();
            end
            else
            begin
                if (!long_told && pressing(now) && now - t_start >= click_ms)
                begin
                    emit_evt(KIND_COMMAND, GEST_LONG, code_now, known_now);
                    long_told = 1'b1;
                end
                if (!long_told && rel_wait && now - t_release > wait_ms)
                    close_clicks();
                else if (long_told && now - t_touch > wait_ms)
                    drop_seq();
            end
        end
        if (is_awake && pinged && now - t_active > sleep_ms)
        begin
            is_awake = 1'b0;
            pinged   = 1'b0;
            emit_evt(KIND_SLEEP, GEST_NONE, '0, 1'b1);
        end
    endfunction

    // results caused by one input transfer, left in fresh
    function automatic void decode_event(row_t it);
        fresh.delete();
        case (it.op)
            OP_PRESS:
                take_press(it.code, it.ctype, it.known, it.stamp);
            OP_RELEASE:
            begin
                is_awake = 1'b1;
                t_active = it.stamp;
                if (in_seq && it.code == (code_now & REL_MASK))
                begin
                    rel_wait  = 1'b1;
                    rel_told  = 1'b0;
                    t_release = it.stamp;
                    t_touch   = it.stamp;
                end
            end
            OP_HOLD:
            begin
                is_awake = 1'b1;
                t_active = it.stamp;
                if (in_seq)
                begin
                    rel_wait = 1'b0;
                    held     = 1'b1;
                    t_hold   = it.stamp;
                    hold_ok  = 1'b1;
                    t_touch  = it.stamp;
                end
            end
            OP_PING:
            begin
                is_awake = 1'b1;
                pinged   = 1'b1;
                t_active = it.stamp;
                emit_evt(KIND_PING, GEST_NONE, '0, 1'b1);
            end
            OP_SLEEP:
            begin
                t_active = it.stamp;
                pinged   = 1'b0;
                is_awake = 1'b0;
                drop_seq();
                emit_evt(KIND_SLEEP, GEST_NONE, '0, 1'b1);
            end
            OP_POLL:
                take_poll(it.stamp);
            default: ;
        endcase
        if (fresh.size() > 0)
            fresh[fresh.size() - 1].last = 1'b1;
    endfunction

    function automatic void predictor_reset();
        click_ms     = 32'd500;
        wait_ms      = 32'd300;
        first_rep_ms = 32'd400;
        later_rep_ms = 32'd100;
        sleep_ms     = 32'd60000;
        chatter_ms   = 32'd50;
        is_awake     = 1'b0;
        pinged       = 1'b0;
        t_active     = '0;
        drop_seq();
    endfunction

    function automatic void set_reg(logic [2:0] idx, logic [23:0] val);
        case (idx)
            CFG_CLICK_TIME:        click_ms     = {16'b0, val[15:0]};
            CFG_WAIT_TIME:         wait_ms      = {16'b0, val[15:0]};
            CFG_FIRST_REPEAT_TIME: first_rep_ms = {16'b0, val[15:0]};
            CFG_LATER_REPEAT_TIME: later_rep_ms = {16'b0, val[15:0]};
            CFG_SLEEP_TIME:        sleep_ms     = {8'b0, val};
            CFG_CHATTER_GAP:       chatter_ms   = {16'b0, val[15:0]};
            default: ;
        endcase
    endfunction

    function automatic row_t row(logic [2:0] op, logic [31:0] code, logic [1:0] ctype,
                                 logic kn, logic [31:0] stamp, int n_typed = PREDICTED,
                                 kind_t ek = KIND_COMMAND, logic [31:0] ec = '0,
                                 logic eknown = 1'b0);
        row_t r;
        r.op      = op;
        r.code    = code;
        r.ctype   = ctype;
        r.known   = kn;
        r.stamp   = stamp;
        r.n_typed = n_typed;
        r.ekind   = ek;
        r.ecode   = ec;
        r.eknown  = eknown;
        return r;
    endfunction

    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [31:0] near(logic [31:0] v);
        return (v > 3) ? $urandom_range(v - 3, v + 3) : $urandom_range(0, v + 3);
    endfunction

    function automatic logic [31:0] step_dt();
        case ($urandom_range(0, 11))
            0, 1, 2: return $urandom_range(0, 40);
            3:       return near(chatter_ms);
            4, 5:    return near(wait_ms);
            6, 7:    return near(click_ms);
            8:       return near(first_rep_ms);
            9:       return near(later_rep_ms);
            10:      return $urandom_range(0, wait_ms + 50);
            default: return ($urandom_range(0, 99) == 0) ? $urandom : $urandom_range(0, 5);
        endcase
    endfunction

    function automatic logic [1:0] pick_type();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5)
            return TYPE_SINGLE;
        if (r < 11)
            return TYPE_REPEATING;
        if (r < 18)
            return TYPE_GESTURE;
        return TYPE_THREE;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic drive_row(row_t it);
        int   gap;
        evt_t e;
        gap = idle_draw();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, it.stamp, it.known, it.ctype, it.code};
        s_axis_tuser  <= it.op;
        do @(posedge clk); while (!s_axis_tready);
        decode_event(it);
        if (it.n_typed == PREDICTED)
        begin
            foreach (fresh[i])
                awaited.push_back(fresh[i]);
        end
        else if (it.n_typed > 0)
        begin
            e.kind  = it.ekind;
            e.gest  = GEST_NONE;
            e.code  = it.ecode;
            e.known = it.eknown;
            e.last  = 1'b1;
            awaited.push_back(e);
        end
        @(negedge clk);
    endtask

    task automatic send(logic [2:0] op, logic [31:0] code, logic [1:0] ctype, logic kn,
                        logic [31:0] dt);
        now_ms = now_ms + dt;
        drive_row(row(op, code, ctype, kn, now_ms));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        set_reg(idx, val);
    endtask

    // drop valid, drain all results, then let the block go idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(int phase);
        case (phase)
            1:
            begin
                write_reg(CFG_CLICK_TIME, {8'($urandom), 16'($urandom_range(100, 800))});
                write_reg(CFG_WAIT_TIME, {8'($urandom), 16'($urandom_range(50, 400))});
                write_reg(CFG_FIRST_REPEAT_TIME,
                          {8'($urandom), 16'($urandom_range(100, 500))});
                write_reg(CFG_LATER_REPEAT_TIME,
                          {8'($urandom), 16'($urandom_range(20, 200))});
                write_reg(CFG_SLEEP_TIME, 24'($urandom_range(500, 5000)));
                write_reg(CFG_CHATTER_GAP, {8'($urandom), 16'($urandom_range(10, 80))});
                write_reg(CFG_SPARE6, 24'($urandom));
                write_reg(CFG_SPARE7, 24'($urandom));
            end
            2:
            begin
                write_reg(CFG_CLICK_TIME, '0);
                write_reg(CFG_WAIT_TIME, '0);
                write_reg(CFG_FIRST_REPEAT_TIME, '0);
                write_reg(CFG_LATER_REPEAT_TIME, '0);
                write_reg(CFG_SLEEP_TIME, '0);
                write_reg(CFG_CHATTER_GAP, '0);
            end
            3:
            begin
                write_reg(CFG_CLICK_TIME, 24'h00FFFF);
                write_reg(CFG_WAIT_TIME, 24'h00FFFF);
                write_reg(CFG_FIRST_REPEAT_TIME, 24'h00FFFF);
                write_reg(CFG_LATER_REPEAT_TIME, 24'h00FFFF);
                write_reg(CFG_SLEEP_TIME, 24'hFFFFFF);
                write_reg(CFG_CHATTER_GAP, 24'h00FFFF);
            end
            default:
            begin
                write_reg(CFG_CLICK_TIME, 24'($urandom_range(0, 300)));
                write_reg(CFG_WAIT_TIME, 24'($urandom_range(0, 300)));
                write_reg(CFG_FIRST_REPEAT_TIME, 24'($urandom_range(0, 300)));
                write_reg(CFG_LATER_REPEAT_TIME, 24'($urandom_range(0, 300)));
                write_reg(CFG_SLEEP_TIME, 24'($urandom_range(0, 3000)));
                write_reg(CFG_CHATTER_GAP, 24'($urandom_range(0, 300)));
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int target);
        int          done;
        int          steps;
        int          r;
        logic [31:0] code;
        logic [1:0]  ctype;
        logic        kn;
        logic [2:0]  op;
        logic [31:0] pool[4];
        pool[0] = $urandom;
        pool[1] = $urandom;
        pool[2] = $urandom_range(0, 255);
        pool[3] = $urandom;
        done = 0;
        while (done < target)
        begin
            if ($urandom_range(0, 29) == 0)
                calm = !calm;
            r = $urandom_range(0, 99);
            if (r < 78)
            begin
                code  = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 3)];
                ctype = pick_type();
                kn    = $urandom_range(0, 1);
                send(OP_PRESS, code, ctype, kn, step_dt());
                done++;
                if ($urandom_range(0, 1) == 0)
                begin
                    // held button: hold reports within the quiet window, polls in between
                    send(OP_POLL, $urandom, $urandom, $urandom, $urandom_range(0, 10));
                    steps = $urandom_range(1, 10);
                    repeat (steps)
                    begin
                        send(OP_HOLD, $urandom, $urandom, $urandom,
                             $urandom_range(0, wait_ms));
                        send(OP_POLL, $urandom, $urandom, $urandom, $urandom_range(0, 10));
                    end
                    send(OP_RELEASE, code & REL_MASK, $urandom, $urandom, step_dt());
                    send(OP_POLL, $urandom, $urandom, $urandom, near(chatter_ms));
                    send(OP_POLL, $urandom, $urandom, $urandom, near(wait_ms));
                    done += 2 * steps + 4;
                end
                else
                begin
                    steps = $urandom_range(1, 8);
                    repeat (steps)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 40)
                            send(OP_POLL, $urandom, $urandom, $urandom, step_dt());
                        else if (r < 52)
                            send(OP_HOLD, $urandom, $urandom, $urandom, step_dt());
                        else if (r < 75)
                            send(OP_RELEASE, code & REL_MASK, $urandom, $urandom, step_dt());
                        else if (r < 80)
                            send(OP_RELEASE, $urandom, $urandom, $urandom, step_dt());
                        else if (r < 95)
                            send(OP_PRESS, code, ctype, kn, step_dt());
                        else
                            send(OP_PRESS, pool[$urandom_range(0, 3)], pick_type(),
                                 $urandom, step_dt());
                        done++;
                    end
                end
            end
            else if (r < 86)
            begin
                send(OP_PING, $urandom, $urandom, $urandom, step_dt());
                done++;
            end
            else if (r < 89)
            begin
                send(OP_SLEEP, $urandom, $urandom, $urandom, step_dt());
                done++;
            end
            else if (r < 95)
            begin
                // inactivity check right around the sleep threshold
                send(OP_POLL, $urandom, $urandom, $urandom,
                     t_active + near(sleep_ms) - now_ms);
                done++;
            end
            else if (r < 98)
                send($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, $urandom, $urandom,
                     $urandom, step_dt());
            else
            begin
                op = $urandom_range(0, 7);
                send(op, $urandom, $urandom, $urandom, $urandom - now_ms);
                if (op <= OP_POLL)
                    done++;
            end
        end
    endtask

    initial
    begin : result_sink
        int gap;
        @(negedge clk);
        forever
        begin
            gap = idle_draw();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : scoreboard
        evt_t got;
        evt_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind  = kind_t'(m_axis_tuser);
            got.gest  = gesture_t'(m_axis_tdata[2:0]);
            got.code  = m_axis_tdata[34:3];
            got.known = m_axis_tdata[35];
            got.last  = m_axis_tlast;
            if (awaited.size() == 0)
            begin
                if (fails < 10)
                    $display("unexpected result: kind=%0d gest=%0d code=%h known=%0d last=%0d",
                             got.kind, got.gest, got.code, got.known, got.last);
                fails++;
            end
            else
            begin
                want = awaited.pop_front();
                if (got.kind !== want.kind || got.gest !== want.gest ||
                    got.code !== want.code || got.known !== want.known ||
                    got.last !== want.last)
                begin
                    if (fails < 10)
                        $display({"mismatch: expected kind=%0d gest=%0d code=%h known=%0d ",
                                  "last=%0d, got kind=%0d gest=%0d code=%h known=%0d last=%0d"},
                                 want.kind, want.gest, want.code, want.known, want.last,
                                 got.kind, got.gest, got.code, got.known, got.last);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial
    begin : watchdog
        wait (quiet >= LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        calm          = 1'b0;
        now_ms        = '0;
        predictor_reset();

        plan.push_back(row(OP_POLL, 32'h0, TYPE_SINGLE, 1'b0, 32'd0, 0));
        plan.push_back(row(OP_SPARE6, 32'hFFFF_FFFF, TYPE_THREE, 1'b1, 32'd5, 0));
        plan.push_back(row(OP_SPARE7, 32'hFFFF_FFFF, TYPE_THREE, 1'b1, 32'd5, 0));
        plan.push_back(row(OP_PING, 32'h0, TYPE_SINGLE, 1'b0, 32'd10, 1,
                           KIND_PING, 32'h0, 1'b1));
        plan.push_back(row(OP_PRESS, 32'hFFFF_FFFF, TYPE_SINGLE, 1'b1, 32'd20, 1,
                           KIND_PRESS, 32'hFFFF_FFFF, 1'b1));
        plan.push_back(row(OP_POLL, 32'h0, TYPE_SINGLE, 1'b0, 32'd30));
        plan.push_back(row(OP_RELEASE, 32'hFF, TYPE_SINGLE, 1'b0, 32'd40));
        plan.push_back(row(OP_POLL, 32'h0, TYPE_SINGLE, 1'b0, 32'd200));
        // repeating command held across the first repeat point
        plan.push_back(row(OP_PRESS, 32'h12, TYPE_REPEATING, 1'b0, 32'd1000));
        plan.push_back(row(OP_POLL, 32'h0, TYPE_SINGLE, 1'b0, 32'd1010));
        plan.push_back(row(OP_HOLD, 32'h0, TYPE_SINGLE, 1'b0, 32'd1400));
        plan.push_back(row(OP_POLL, 32'h0, TYPE_SINGLE, 1'b0, 32'd1420));
        // double click
        plan.push_back(row(OP_PRESS, 32'h5A5A_00AB, TYPE_GESTURE, 1'b1, 32'd2000));
        plan.push_back(row(OP_RELEASE, 32'hAB, TYPE_SINGLE, 1'b0, 32'd2100));
        plan.push_back(row(OP_PRESS, 32'h5A5A_00AB, TYPE_GESTURE, 1'b1, 32'd2200));
        plan.push_back(row(OP_RELEASE, 32'hAB, TYPE_SINGLE, 1'b0, 32'd2250));
        plan.push_back(row(OP_POLL, 32'h0, TYPE_SINGLE, 1'b0, 32'd2600));
        // type three: bounce, then a poll past the wait time (no long press)
        plan.push_back(row(OP_PRESS, 32'h5, TYPE_THREE, 1'b0, 32'd3000));
        plan.push_back(row(OP_PRESS, 32'h5, TYPE_THREE, 1'b0, 32'd3010));
        plan.push_back(row(OP_POLL, 32'h0, TYPE_SINGLE, 1'b0, 32'd3600));
        // release and quick re-press after a long press continues the hold
        plan.push_back(row(OP_PRESS, 32'h7, TYPE_GESTURE, 1'b1, 32'd4000));
        plan.push_back(row(OP_RELEASE, 32'h7, TYPE_SINGLE, 1'b0, 32'd4600));
        plan.push_back(row(OP_PRESS, 32'h7, TYPE_GESTURE, 1'b1, 32'd4620));
        plan.push_back(row(OP_SLEEP, 32'h0, TYPE_SINGLE, 1'b0, 32'd5000, 1,
                           KIND_SLEEP, 32'h0, 1'b1));
        plan.push_back(row(OP_PING, 32'h0, TYPE_SINGLE, 1'b0, 32'd5000, 1,
                           KIND_PING, 32'h0, 1'b1));
        plan.push_back(row(OP_POLL, 32'h0, TYPE_SINGLE, 1'b0, 32'd70000));
        // time wraps between press and poll
        plan.push_back(row(OP_PRESS, 32'h0, TYPE_SINGLE, 1'b0, 32'hFFFF_FF00));
        plan.push_back(row(OP_POLL, 32'h0, TYPE_SINGLE, 1'b0, 32'h0000_0010));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
            drive_row(plan[i]);

        now_ms = $urandom;
        for (int phase = 1; phase <= 4; phase++)
        begin
            drain();
            configure(phase);
            run_random(PHASE_ITEMS);
        end

        s_axis_tvalid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
